[rtl/tcw_pkg.sv]
package tcw_pkg;

    // one character cell as stored in the text buffer
    typedef struct packed {
        logic [3:0] bg;
        logic [3:0] fg;
        logic [7:0] ch;
    } t_cell;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam int        CFG_IDX_W = 1;
    localparam logic [0:0] CFG_FG   = 1'b0;
    localparam logic [0:0] CFG_BG   = 1'b1;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [3:0] FG_RESET     = 4'd15;
    localparam logic [3:0] BG_RESET     = 4'd0;

endpackage

[rtl/tcw_cell_ram.sv]
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  tcw_pkg::t_cell   i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output tcw_pkg::t_cell   o_rdata
);
    import tcw_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/text_console_writer.sv]
// text console writer: a grid of ROWS x COLUMNS character cells with a cursor
// input channel (i_in_valid/o_in_ready) takes one request per beat:
//   put character (newline moves the cursor to the next row), clear, read cell
// output channel (o_out_valid/i_out_ready) returns exactly one result beat per
// request: cursor after the request, scroll flag and the read cell fields
// config channel (i_cfg_valid/o_cfg_ready) writes the fg/bg colors; always ready
// the cells live in one single-port-write, registered-read ram
// a put passes S_PUT then S_DONE, a read S_READ then S_DONE, an unused code goes
// straight to S_DONE, a clear walks every cell in S_CLEAR, and a put that scrolls
// adds S_SCROLL and S_DRAIN before S_DONE (the scroll walks every cell once, one
// ram write per cycle); one request is in flight at a time; input ready rises in
// the same cycle as the result is loaded into the output register, even if the
// receiver stalls it
// while a stalled result fills the output register and the next one is waiting,
// input ready stays low
// after reset a clearing pass in S_INIT zeroes every cell of the ram; input
// ready stays low until it ends, config writes are taken throughout
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [10:0] o_cursor_pos,
    output logic        o_scrolled,
    output logic [7:0]  o_read_char,
    output logic [3:0]  o_read_fg,
    output logic [3:0]  o_read_bg,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_END   = CELL_COUNT - COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(CELL_COUNT + 1);
    localparam int CLW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_PUT, S_CLEAR, S_READ, S_SCROLL, S_DRAIN, S_DONE
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_ptr;
    logic [CW-1:0]   r_cursor;
    logic [CLW-1:0]  r_col;
    logic [3:0]      r_fg;
    logic [3:0]      r_bg;
    logic [7:0]      r_char;
    logic            r_rd_ok;
    logic            r_scrolled;
    logic [7:0]      r_res_char;
    logic [3:0]      r_res_fg;
    logic [3:0]      r_res_bg;
    logic            r_pw_valid;
    logic [AW-1:0]   r_pw_addr;
    logic            r_pw_copy;
    logic            r_out_valid;
    logic [10:0]     r_out_cursor;
    logic            r_out_scrolled;
    logic [7:0]      r_out_char;
    logic [3:0]      r_out_fg;
    logic [3:0]      r_out_bg;

    logic [CW-1:0]   n_cursor;
    logic [CLW-1:0]  n_col;
    logic            in_fire;
    logic            ptr_last;
    logic            w_copy;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_cell           ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    t_cell           ram_rdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign ptr_last    = (r_ptr == AW'(CELL_COUNT - 1));
    // rows above the bottom are copied from one row below, the bottom row is zeroed
    assign w_copy      = (32'(r_ptr) < COPY_END);

    always_comb begin
        if (r_char == NEWLINE_CODE) begin
            n_cursor = r_cursor - CW'(r_col) + CW'(COLUMNS);
            n_col    = '0;
        end else begin
            n_cursor = r_cursor + CW'(1);
            n_col    = (r_col == CLW'(COLUMNS - 1)) ? '0 : r_col + CLW'(1);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (r_state)
            S_INIT, S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                ram_re    = in_fire && (i_req_type == REQ_READ);
                ram_raddr = AW'(i_cell_index);
            end
            S_PUT: begin
                ram_we    = (r_char != NEWLINE_CODE);
                ram_waddr = AW'(r_cursor);
                ram_wdata = '{bg: r_bg, fg: r_fg, ch: r_char};
            end
            S_SCROLL, S_DRAIN: begin
                // write comes in the cycle after the copy read
                ram_we    = r_pw_valid;
                ram_waddr = r_pw_addr;
                ram_wdata = r_pw_copy ? ram_rdata : '0;
                ram_re    = (r_state == S_SCROLL) && w_copy;
                ram_raddr = r_ptr + AW'(COLUMNS);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    tcw_cell_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_cursor    <= '0;
            r_col       <= '0;
            r_fg        <= FG_RESET;
            r_bg        <= BG_RESET;
            r_pw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FG:  r_fg <= i_cfg_data;
                    CFG_BG:  r_bg <= i_cfg_data;
                    default: r_fg <= r_fg;
                endcase
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    if (ptr_last) begin
                        r_ptr   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_char     <= i_char_code;
                        r_rd_ok    <= (32'(i_cell_index) < CELL_COUNT);
                        r_scrolled <= 1'b0;
                        r_res_char <= '0;
                        r_res_fg   <= '0;
                        r_res_bg   <= '0;
                        case (i_req_type)
                            REQ_PUT: begin
                                r_state <= S_PUT;
                            end
                            REQ_CLEAR: begin
                                r_cursor <= '0;
                                r_col    <= '0;
                                r_ptr    <= '0;
                                r_state  <= S_CLEAR;
                            end
                            REQ_READ: begin
                                r_state <= S_READ;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_PUT: begin
                    if (n_cursor == CW'(CELL_COUNT)) begin
                        r_cursor   <= CW'(COPY_END);
                        r_col      <= '0;
                        r_scrolled <= 1'b1;
                        r_ptr      <= '0;
                        r_pw_valid <= 1'b0;
                        r_state    <= S_SCROLL;
                    end else begin
                        r_cursor <= n_cursor;
                        r_col    <= n_col;
                        r_state  <= S_DONE;
                    end
                end
                S_CLEAR: begin
                    if (ptr_last) begin
                        r_ptr   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_ptr <= r_ptr + AW'(1);
                    end
                end
                S_READ: begin
                    if (r_rd_ok) begin
                        r_res_char <= ram_rdata.ch;
                        r_res_fg   <= ram_rdata.fg;
                        r_res_bg   <= ram_rdata.bg;
                    end
                    r_state <= S_DONE;
                end
                S_SCROLL: begin
                    r_pw_valid <= 1'b1;
                    r_pw_addr  <= r_ptr;
                    r_pw_copy  <= w_copy;
                    if (ptr_last) begin
                        r_ptr   <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_ptr <= r_ptr + AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_pw_valid <= 1'b0;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_cursor   <= 11'(r_cursor);
                        r_out_scrolled <= r_scrolled;
                        r_out_char     <= r_res_char;
                        r_out_fg       <= r_res_fg;
                        r_out_bg       <= r_res_bg;
                        r_state        <= S_IDLE;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_out_cursor;
    assign o_scrolled   = r_out_scrolled;
    assign o_read_char  = r_out_char;
    assign o_read_fg    = r_out_fg;
    assign o_read_bg    = r_out_bg;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor < CW'(CELL_COUNT))
        else $error("cursor beyond the grid");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CLW'(COLUMNS - 1))
        else $error("column counter beyond the row");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |-> o_cursor_pos == 11'(COPY_END))
        else $error("scroll result without cursor at bottom row start");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("second request taken while one is in flight");

endmodule
